/* hdl/lcd_mode_timing_controller_core_macros.svh */
// ----------------------------------------------------------------------------
// LCD mode timing controller: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_CONTROLLER_CORE_MACROS_SVH
`define LCD_MODE_TIMING_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lmtc_pkg.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller package
// Request and response types, commands, register map and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;

  localparam logic [16:0] FRAME_DOTS  = 17'd70224;
  localparam logic [16:0] HBLANK_DOTS = 17'd204;
  localparam logic [16:0] LINE_DOTS   = 17'd456;
  localparam logic [16:0] OAM_DOTS    = 17'd80;
  localparam logic [16:0] XFER_DOTS   = 17'd172;
  localparam logic [16:0] PIXEL_START = 17'd12;

  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LINE_COUNT        = 8'd154;

  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [7:0] STAT_RESET = 8'h85;
  localparam logic [7:0] DMA_RESET  = 8'hFF;
  localparam logic [7:0] BGP_RESET  = 8'hFC;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        dma_busy;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] mode;
    logic [7:0] line;
    logic       vblank_request;
    logic       stat_request;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic       dma_start;
    logic [7:0] dma_page;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/lmtc_if.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        dma_busy;

  modport source (output valid, command, address, write_data, dma_busy, input ready);
  modport sink   (input valid, command, address, write_data, dma_busy, output ready);
endinterface

interface lmtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] mode;
  logic [7:0] line;
  logic       vblank_request;
  logic       stat_request;
  logic       pixel_valid;
  logic [7:0] pixel_x;
  logic       dma_start;
  logic [7:0] dma_page;

  modport source (output valid, read_data, mode, line, vblank_request, stat_request,
                  pixel_valid, pixel_x, dma_start, dma_page, input ready);
  modport sink   (input valid, read_data, mode, line, vblank_request, stat_request,
                  pixel_valid, pixel_x, dma_start, dma_page, output ready);
endinterface

`default_nettype wire

/* hdl/lcd_mode_timing_controller_core.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller core
// Dot-driven line and frame sequencer with the twelve LCD registers.
// ----------------------------------------------------------------------------
// Each request on req_i is one dot tick, one register read or one register
// write; each request gives exactly one response on rsp_o, in order.
// A request is registered at acceptance in the input register; its response
// is computed from that register and the block state and is loaded into the
// response register once that register is free.
// The block takes one request per cycle while the receiver takes responses;
// the dot counter and register update between the two registers is combinational.
// The response register lets a new request be taken while a finished
// response still waits; when the receiver stalls, the input register fills
// and req_i.ready falls until the response is taken.
// Reset clears both handshakes and sets the LCD registers, the dot counter
// and the mode to their power-on values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_controller_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lmtc_req_if.sink   req_i,
  lmtc_rsp_if.source rsp_o
);
  import lmtc_pkg::*;

  logic req_valid;
  logic out_free;
  logic step;
  req_t req;
  rsp_t rsp;

  assign step = req_valid && out_free;

  lmtc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (out_free),
    .valid_o (req_valid),
    .req_o   (req)
  );

  lmtc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  lmtc_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .rsp_i  (rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

/* hdl/lmtc_in_stage.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller input stage
// Registers one request and holds it until the sequencer can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtc_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lmtc_req_if.sink           req_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output lmtc_pkg::req_t     req_o
);
  import lmtc_pkg::*;

  logic valid_q;
  req_t req_q;

  assign req_i.ready = !valid_q || take_i;
  assign valid_o     = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.command    <= req_i.command;
      req_q.address    <= req_i.address;
      req_q.write_data <= req_i.write_data;
      req_q.dma_busy   <= req_i.dma_busy;
    end
  end

endmodule

`default_nettype wire

/* hdl/lmtc_engine.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller sequencer
// Dot counter, line and mode sequencing, LCD registers and interrupt pulses.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_mode_timing_controller_core_macros.svh"

module lmtc_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire lmtc_pkg::req_t req_i,
  output lmtc_pkg::rsp_t     rsp_o
);
  import lmtc_pkg::*;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  logic [16:0] dot_q, dot_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  lcdc_q, lcdc_d;
  logic [7:0]  stat_q, stat_d;
  logic [7:0]  scy_q, scy_d;
  logic [7:0]  scx_q, scx_d;
  logic [7:0]  ly_q, ly_d;
  logic [7:0]  lyc_q, lyc_d;
  logic [7:0]  dma_q, dma_d;
  logic [7:0]  bgp_q, bgp_d;
  logic [7:0]  obp0_q, obp0_d;
  logic [7:0]  obp1_q, obp1_d;
  logic [7:0]  wy_q, wy_d;
  logic [7:0]  wx_q, wx_d;

  logic [16:0] dot_inc;
  logic [16:0] pix_off;
  logic [7:0]  ly_inc;
  logic        match;
  rsp_t        rsp;

  assign dot_inc = dot_q + 17'd1;
  assign pix_off = dot_inc - PIXEL_START;
  assign ly_inc  = ly_q + 8'd1;

  always_comb begin
    dot_d  = dot_q;
    mode_d = mode_q;
    lcdc_d = lcdc_q;
    stat_d = stat_q;
    scy_d  = scy_q;
    scx_d  = scx_q;
    ly_d   = ly_q;
    lyc_d  = lyc_q;
    dma_d  = dma_q;
    bgp_d  = bgp_q;
    obp0_d = obp0_q;
    obp1_d = obp1_q;
    wy_d   = wy_q;
    wx_d   = wx_q;
    match  = 1'b0;
    rsp    = '0;
    if (step_i) begin
      case (cmd_e'(req_i.command))
        CMD_TICK: begin
          dot_d = dot_inc;
          if (!lcdc_q[7]) begin
            if (dot_inc >= FRAME_DOTS) begin
              dot_d = dot_inc - FRAME_DOTS;
            end
          end else begin
            case (mode_q)
              MODE_HBLANK: begin
                if (dot_inc >= HBLANK_DOTS) begin
                  dot_d     = dot_inc - HBLANK_DOTS;
                  ly_d      = ly_inc;
                  match     = (ly_inc == lyc_q);
                  stat_d[2] = match;
                  rsp.stat_request = match && stat_q[6];
                  if (ly_inc == FIRST_VBLANK_LINE) begin
                    mode_d = MODE_VBLANK;
                    rsp.vblank_request = 1'b1;
                    if (stat_q[4]) begin
                      rsp.stat_request = 1'b1;
                    end
                  end else begin
                    mode_d = MODE_OAM;
                    if (stat_q[5]) begin
                      rsp.stat_request = 1'b1;
                    end
                  end
                end
              end
              MODE_VBLANK: begin
                if (dot_inc >= LINE_DOTS) begin
                  dot_d = dot_inc - LINE_DOTS;
                  if (ly_inc == LINE_COUNT) begin
                    ly_d   = 8'd0;
                    match  = (lyc_q == 8'd0);
                    mode_d = MODE_OAM;
                    rsp.stat_request = (match && stat_q[6]) || stat_q[5];
                  end else begin
                    ly_d  = ly_inc;
                    match = (ly_inc == lyc_q);
                    rsp.stat_request = match && stat_q[6];
                  end
                  stat_d[2] = match;
                end
              end
              MODE_OAM: begin
                if (dot_inc >= OAM_DOTS) begin
                  dot_d  = dot_inc - OAM_DOTS;
                  mode_d = MODE_XFER;
                end
              end
              default: begin
                if (dot_inc >= PIXEL_START && dot_inc < XFER_DOTS) begin
                  rsp.pixel_valid = 1'b1;
                  rsp.pixel_x     = pix_off[7:0];
                end else if (dot_inc >= XFER_DOTS) begin
                  dot_d  = dot_inc - XFER_DOTS;
                  mode_d = MODE_HBLANK;
                  rsp.stat_request = stat_q[3];
                end
              end
            endcase
            if (mode_d != mode_q) begin
              stat_d[1:0] = mode_d;
            end
          end
        end
        CMD_READ: begin
          case (req_i.address)
            ADDR_LCDC: rsp.read_data = lcdc_q;
            ADDR_STAT: rsp.read_data = stat_q;
            ADDR_SCY:  rsp.read_data = scy_q;
            ADDR_SCX:  rsp.read_data = scx_q;
            ADDR_LY:   rsp.read_data = ly_q;
            ADDR_LYC:  rsp.read_data = lyc_q;
            ADDR_DMA:  rsp.read_data = dma_q;
            ADDR_BGP:  rsp.read_data = bgp_q;
            ADDR_OBP0: rsp.read_data = obp0_q;
            ADDR_OBP1: rsp.read_data = obp1_q;
            ADDR_WY:   rsp.read_data = wy_q;
            ADDR_WX:   rsp.read_data = wx_q;
            default:   rsp.read_data = 8'd0;
          endcase
        end
        CMD_WRITE: begin
          case (req_i.address)
            ADDR_LCDC: lcdc_d = req_i.write_data;
            ADDR_STAT: stat_d = {req_i.write_data[7:2], stat_q[1:0]};
            ADDR_SCY:  scy_d  = req_i.write_data;
            ADDR_SCX:  scx_d  = req_i.write_data;
            ADDR_LY:   ly_d   = req_i.write_data;
            ADDR_LYC:  lyc_d  = req_i.write_data;
            ADDR_DMA: begin
              if (!req_i.dma_busy) begin
                dma_d         = req_i.write_data;
                rsp.dma_start = 1'b1;
                rsp.dma_page  = req_i.write_data;
              end
            end
            ADDR_BGP:  bgp_d  = req_i.write_data;
            ADDR_OBP0: obp0_d = req_i.write_data;
            ADDR_OBP1: obp1_d = req_i.write_data;
            ADDR_WY:   wy_d   = req_i.write_data;
            ADDR_WX:   wx_d   = req_i.write_data;
            default:   ;
          endcase
        end
        default: ;
      endcase
    end
    rsp.mode = mode_d;
    rsp.line = ly_d;
  end

  assign rsp_o = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= 17'd0;
      mode_q <= MODE_OAM;
      lcdc_q <= LCDC_RESET;
      stat_q <= STAT_RESET;
      scy_q  <= 8'd0;
      scx_q  <= 8'd0;
      ly_q   <= 8'd0;
      lyc_q  <= 8'd0;
      dma_q  <= DMA_RESET;
      bgp_q  <= BGP_RESET;
      obp0_q <= 8'd0;
      obp1_q <= 8'd0;
      wy_q   <= 8'd0;
      wx_q   <= 8'd0;
    end else if (step_i) begin
      dot_q  <= dot_d;
      mode_q <= mode_d;
      lcdc_q <= lcdc_d;
      stat_q <= stat_d;
      scy_q  <= scy_d;
      scx_q  <= scx_d;
      ly_q   <= ly_d;
      lyc_q  <= lyc_d;
      dma_q  <= dma_d;
      bgp_q  <= bgp_d;
      obp0_q <= obp0_d;
      obp1_q <= obp1_d;
      wy_q   <= wy_d;
      wx_q   <= wx_d;
    end
  end

  `LMTC_ASSERT_SAME(a_dot_in_frame, clk_i, rst_ni, 1'b1, dot_q < FRAME_DOTS, "dot count beyond frame")
  `LMTC_ASSERT_SAME(a_pixel_in_xfer, clk_i, rst_ni, step_i && rsp.pixel_valid, rsp.mode == MODE_XFER, "pixel slot outside transfer")
  `LMTC_ASSERT_SAME(a_vblank_line, clk_i, rst_ni, step_i && rsp.vblank_request, (rsp.mode == MODE_VBLANK) && (rsp.line == FIRST_VBLANK_LINE), "vblank request off its line")
  `LMTC_ASSERT_NEXT(a_dma_stored, clk_i, rst_ni, step_i && rsp.dma_start, dma_q == $past(rsp.dma_page), "DMA page not stored")

endmodule

`default_nettype wire

/* hdl/lmtc_out_stage.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller output stage
// Result register that holds a response until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtc_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire lmtc_pkg::rsp_t rsp_i,
  output logic                free_o,
  lmtc_rsp_if.source          rsp_o
);
  import lmtc_pkg::*;

  logic valid_q;
  rsp_t rsp_q;

  assign free_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.read_data      = rsp_q.read_data;
  assign rsp_o.mode           = rsp_q.mode;
  assign rsp_o.line           = rsp_q.line;
  assign rsp_o.vblank_request = rsp_q.vblank_request;
  assign rsp_o.stat_request   = rsp_q.stat_request;
  assign rsp_o.pixel_valid    = rsp_q.pixel_valid;
  assign rsp_o.pixel_x        = rsp_q.pixel_x;
  assign rsp_o.dma_start      = rsp_q.dma_start;
  assign rsp_o.dma_page       = rsp_q.dma_page;

endmodule

`default_nettype wire

/* tb/sv/tb_lcd_mode_timing_controller_core.sv */
// ----------------------------------------------------------------------------
// LCD mode timing controller core testbench
// Drives dot ticks and register accesses through the request channel and
// checks every response against a cycle-free model of the line and frame
// sequencer, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lmtc_pkg::*;

  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam int STAT_LYC_FLAG = 2;
  localparam int STAT_HBLANK_IE = 3;
  localparam int STAT_VBLANK_IE = 4;
  localparam int STAT_OAM_IE = 5;
  localparam int STAT_LYC_IE = 6;
  localparam int LCDC_ENABLE = 7;

  logic clk_i = 1'b0;
  logic rst_ni;

  lmtc_req_if req_if ();
  lmtc_rsp_if rsp_if ();

  lcd_mode_timing_controller_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Model state of the sequencer and the LCD registers.
  logic [16:0] dot_ctr;
  logic [1:0]  lcd_mode;
  logic [7:0]  reg_lcdc, reg_stat, reg_scy, reg_scx, reg_ly, reg_lyc;
  logic [7:0]  reg_dma, reg_bgp, reg_obp0, reg_obp1, reg_wy, reg_wx;

  rsp_t        lcd_result_q[$];
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;

  function automatic void reset_lcd_state();
    dot_ctr  = '0;
    lcd_mode = MODE_OAM;
    reg_lcdc = LCDC_RESET;
    reg_stat = STAT_RESET;
    reg_scy  = '0;
    reg_scx  = '0;
    reg_ly   = '0;
    reg_lyc  = '0;
    reg_dma  = DMA_RESET;
    reg_bgp  = BGP_RESET;
    reg_obp0 = '0;
    reg_obp1 = '0;
    reg_wy   = '0;
    reg_wx   = '0;
  endfunction

  function automatic logic refresh_coincidence();
    reg_stat[STAT_LYC_FLAG] = (reg_ly == reg_lyc);
    return (reg_ly == reg_lyc) && reg_stat[STAT_LYC_IE];
  endfunction

  function automatic void enter_mode(logic [1:0] m);
    lcd_mode = m;
    reg_stat[1:0] = m;
  endfunction

  function automatic rsp_t lcd_timing_step(req_t r);
    rsp_t o;
    o = '0;
    case (r.command)
      CMD_TICK: begin
        dot_ctr = dot_ctr + 17'd1;
        if (!reg_lcdc[LCDC_ENABLE]) begin
          if (dot_ctr >= FRAME_DOTS) dot_ctr = dot_ctr - FRAME_DOTS;
        end else begin
          case (lcd_mode)
            MODE_HBLANK: begin
              if (dot_ctr >= HBLANK_DOTS) begin
                dot_ctr = dot_ctr - HBLANK_DOTS;
                reg_ly = reg_ly + 8'd1;
                if (refresh_coincidence()) o.stat_request = 1'b1;
                if (reg_ly == FIRST_VBLANK_LINE) begin
                  enter_mode(MODE_VBLANK);
                  o.vblank_request = 1'b1;
                  if (reg_stat[STAT_VBLANK_IE]) o.stat_request = 1'b1;
                end else begin
                  enter_mode(MODE_OAM);
                  if (reg_stat[STAT_OAM_IE]) o.stat_request = 1'b1;
                end
              end
            end
            MODE_VBLANK: begin
              if (dot_ctr >= LINE_DOTS) begin
                dot_ctr = dot_ctr - LINE_DOTS;
                reg_ly = reg_ly + 8'd1;
                if (reg_ly == LINE_COUNT) begin
                  reg_ly = '0;
                  if (refresh_coincidence()) o.stat_request = 1'b1;
                  enter_mode(MODE_OAM);
                  if (reg_stat[STAT_OAM_IE]) o.stat_request = 1'b1;
                end else if (refresh_coincidence()) begin
                  o.stat_request = 1'b1;
                end
              end
            end
            MODE_OAM: begin
              if (dot_ctr >= OAM_DOTS) begin
                dot_ctr = dot_ctr - OAM_DOTS;
                enter_mode(MODE_XFER);
              end
            end
            default: begin
              if (dot_ctr >= PIXEL_START && dot_ctr < XFER_DOTS) begin
                o.pixel_valid = 1'b1;
                o.pixel_x = 8'(dot_ctr - PIXEL_START);
              end else if (dot_ctr >= XFER_DOTS) begin
                dot_ctr = dot_ctr - XFER_DOTS;
                enter_mode(MODE_HBLANK);
                if (reg_stat[STAT_HBLANK_IE]) o.stat_request = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_READ: begin
        case (r.address)
          ADDR_LCDC: o.read_data = reg_lcdc;
          ADDR_STAT: o.read_data = reg_stat;
          ADDR_SCY:  o.read_data = reg_scy;
          ADDR_SCX:  o.read_data = reg_scx;
          ADDR_LY:   o.read_data = reg_ly;
          ADDR_LYC:  o.read_data = reg_lyc;
          ADDR_DMA:  o.read_data = reg_dma;
          ADDR_BGP:  o.read_data = reg_bgp;
          ADDR_OBP0: o.read_data = reg_obp0;
          ADDR_OBP1: o.read_data = reg_obp1;
          ADDR_WY:   o.read_data = reg_wy;
          ADDR_WX:   o.read_data = reg_wx;
          default:   o.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (r.address)
          ADDR_LCDC: reg_lcdc = r.write_data;
          ADDR_STAT: reg_stat = {r.write_data[7:2], reg_stat[1:0]};
          ADDR_SCY:  reg_scy = r.write_data;
          ADDR_SCX:  reg_scx = r.write_data;
          ADDR_LY:   reg_ly = r.write_data;
          ADDR_LYC:  reg_lyc = r.write_data;
          ADDR_DMA: begin
            if (!r.dma_busy) begin
              reg_dma = r.write_data;
              o.dma_start = 1'b1;
              o.dma_page = r.write_data;
            end
          end
          ADDR_BGP:  reg_bgp = r.write_data;
          ADDR_OBP0: reg_obp0 = r.write_data;
          ADDR_OBP1: reg_obp1 = r.write_data;
          ADDR_WY:   reg_wy = r.write_data;
          ADDR_WX:   reg_wx = r.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    o.mode = lcd_mode;
    o.line = reg_ly;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    req_t taken;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (lcd_result_q.size() == 0) begin
          $error("response taken with no request outstanding");
          error_count++;
        end else begin
          want = lcd_result_q.pop_front();
          check_field("read_data", want.read_data, rsp_if.read_data);
          check_field("mode", 8'(want.mode), 8'(rsp_if.mode));
          check_field("line", want.line, rsp_if.line);
          check_field("vblank_request", 8'(want.vblank_request), 8'(rsp_if.vblank_request));
          check_field("stat_request", 8'(want.stat_request), 8'(rsp_if.stat_request));
          check_field("pixel_valid", 8'(want.pixel_valid), 8'(rsp_if.pixel_valid));
          check_field("pixel_x", want.pixel_x, rsp_if.pixel_x);
          check_field("dma_start", 8'(want.dma_start), 8'(rsp_if.dma_start));
          check_field("dma_page", want.dma_page, rsp_if.dma_page);
        end
      end
      if (req_if.valid && req_if.ready) begin
        taken.command    = req_if.command;
        taken.address    = req_if.address;
        taken.write_data = req_if.write_data;
        taken.dma_busy   = req_if.dma_busy;
        lcd_result_q.push_back(lcd_timing_step(taken));
      end
    end
  end

  // The response side stalls at random, or for a fixed stretch when asked.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] data, input logic busy);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.command    = cmd;
    req_if.address    = addr;
    req_if.write_data = data;
    req_if.dma_busy   = busy;
    req_if.valid      = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    requests_sent++;
  endtask

  task automatic wait_for_responses();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (lcd_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_dots(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_request(CMD_READ, ADDR_LCDC + 16'($urandom_range(11)), 8'($urandom), 1'($urandom));
      else
        send_request(CMD_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic approach_line_event();
    int rem;
    logic [7:0] target;
    if (!reg_lcdc[LCDC_ENABLE])
      send_request(CMD_WRITE, ADDR_LCDC, {1'b1, 7'($urandom)}, 1'b0);
    send_request(CMD_WRITE, ADDR_STAT, 8'($urandom), 1'($urandom));
    if (lcd_mode == MODE_VBLANK) begin
      case ($urandom_range(3))
        0: target = 8'd152;
        1: target = 8'd153;
        2: target = 8'($urandom_range(153, 144));
        default: target = 8'($urandom);
      endcase
    end else begin
      case ($urandom_range(4))
        0: target = 8'd142;
        1: target = 8'd143;
        2: target = 8'd254;
        3: target = 8'd255;
        default: target = 8'($urandom);
      endcase
    end
    send_request(CMD_WRITE, ADDR_LY, target, 1'($urandom));
    case ($urandom_range(3))
      0, 1: send_request(CMD_WRITE, ADDR_LYC, target + 8'd1, 1'($urandom));
      2: send_request(CMD_WRITE, ADDR_LYC, 8'd0, 1'($urandom));
      default: send_request(CMD_WRITE, ADDR_LYC, 8'($urandom), 1'($urandom));
    endcase
    case (lcd_mode)
      MODE_HBLANK: rem = int'(HBLANK_DOTS) - int'(dot_ctr);
      MODE_XFER: rem = int'(XFER_DOTS + HBLANK_DOTS) - int'(dot_ctr);
      MODE_OAM: rem = int'(OAM_DOTS + XFER_DOTS + HBLANK_DOTS) - int'(dot_ctr);
      default: rem = int'(LINE_DOTS) - int'(dot_ctr);
    endcase
    if (rem < 1) rem = 1;
    run_dots(rem + $urandom_range(30));
  endtask

  task automatic toggle_display();
    send_request(CMD_WRITE, ADDR_LCDC, {1'b0, 7'($urandom)}, 1'($urandom));
    run_dots($urandom_range(300, 20));
    send_request(CMD_WRITE, ADDR_LCDC, {1'b1, 7'($urandom)}, 1'($urandom));
    run_dots($urandom_range(40, 5));
  endtask

  task automatic register_burst();
    repeat (8)
      send_request($urandom_range(1) ? CMD_WRITE : CMD_READ,
                   ADDR_LCDC + 16'($urandom_range(11)), 8'($urandom), 1'($urandom));
  endtask

  task automatic random_noise();
    logic [15:0] addr;
    repeat (6) begin
      addr = $urandom_range(1) ? 16'($urandom) : ADDR_LCDC - 16'd2 + 16'($urandom_range(15));
      send_request(2'($urandom_range(3)), addr, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_reset_values();
    for (logic [15:0] a = ADDR_LCDC; a <= ADDR_WX; a++)
      send_request(CMD_READ, a, 8'h00, 1'b0);
    wait_for_responses();
  endtask

  task automatic test_register_special_cases();
    send_request(CMD_READ, 16'h0000, 8'h00, 1'b0);
    send_request(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1);
    send_request(CMD_READ, 16'hFF4C, 8'h00, 1'b0);
    send_request(CMD_WRITE, 16'hFF3F, 8'hAA, 1'b0);
    send_request(CMD_WRITE, ADDR_STAT, 8'hFF, 1'b0);
    send_request(CMD_READ, ADDR_STAT, 8'h00, 1'b0);
    send_request(CMD_WRITE, ADDR_LY, 8'd7, 1'b0);
    send_request(CMD_WRITE, ADDR_LYC, 8'd7, 1'b0);
    send_request(CMD_READ, ADDR_STAT, 8'h00, 1'b0);
    send_request(CMD_WRITE, ADDR_DMA, 8'h00, 1'b1);
    send_request(CMD_READ, ADDR_DMA, 8'h00, 1'b0);
    send_request(CMD_WRITE, ADDR_DMA, 8'hC3, 1'b0);
    send_request(CMD_NONE, 16'hFFFF, 8'hFF, 1'b1);
    wait_for_responses();
  endtask

  task automatic test_frame_timing(input int unsigned idle, input int unsigned stall,
                                   input int unsigned count);
    int unsigned start;
    int unsigned kind;
    idle_pct = idle;
    stall_pct = stall;
    start = requests_sent;
    while (requests_sent - start < count) begin
      kind = $urandom_range(9);
      if (kind < 6) approach_line_event();
      else if (kind < 8) toggle_display();
      else if (kind == 8) register_burst();
      else random_noise();
    end
    wait_for_responses();
  endtask

  task automatic test_response_holdoff();
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 120;
    run_dots(40);
    wait_for_responses();
  endtask

  initial begin
    reset_lcd_state();
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_TICK;
    req_if.address = '0;
    req_if.write_data = '0;
    req_if.dma_busy = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_register_special_cases();
    test_frame_timing(0, 0, 450);
    test_frame_timing(53, 0, 450);
    test_frame_timing(0, 53, 450);
    test_frame_timing(31, 31, 450);
    test_response_holdoff();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lmtc_pkg.sv
hdl/lmtc_if.sv
hdl/lmtc_in_stage.sv
hdl/lmtc_engine.sv
hdl/lmtc_out_stage.sv
hdl/lcd_mode_timing_controller_core.sv
tb/sv/tb_lcd_mode_timing_controller_core.sv
